// ===== design/path_obstacle_proximity_checker_assert.svh =====
// assertion macros for the path obstacle proximity checker
// expects signals named clk and rst_n in the module that uses them
`ifndef PATH_OBSTACLE_PROXIMITY_CHECKER_ASSERT_SVH
`define PATH_OBSTACLE_PROXIMITY_CHECKER_ASSERT_SVH

// same-cycle implication, masked during reset
`define POPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define POPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/popc_pkg.sv =====
// shared types and constants for the path obstacle proximity checker
// no dependencies; used by popc_within and the top level
package popc_pkg;

    // item kinds on the input channel
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_OBSTACLE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PATH     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MISSION  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd4;

    // result kinds
    localparam logic RES_VERDICT = 1'b0;
    localparam logic RES_GOAL    = 1'b1;

    // register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PATH_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAR_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIT_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACC_MISSION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_X      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_RADIUS = 3'd6;

    // field widths
    localparam int LIM_W     = 16;
    localparam int MISSION_W = 8;
    localparam int HLIM_W    = 8;
    localparam int HIT_W     = 9;
    localparam logic [HIT_W-1:0] HIT_MAX = 9'd511;

    // register reset values
    localparam logic [LIM_W-1:0]     PATH_LIMIT_RST  = 16'd179;
    localparam logic [LIM_W-1:0]     CAR_LIMIT_RST   = 16'd2560;
    localparam logic [HLIM_W-1:0]    HIT_LIMIT_RST   = 8'd1;
    localparam logic [MISSION_W-1:0] ACC_MISSION_RST = 8'd5;
    localparam int                   GOAL_X_RST      = 157184;
    localparam int                   GOAL_Y_RST      = -142080;
    localparam logic [LIM_W-1:0]     GOAL_RADIUS_RST = 16'd768;

endpackage

// ===== design/popc_within.sv =====
// pipelined distance test: |a-b|^2 < lim^2, result registered after the sum and compare stage
// depends on popc_pkg
module popc_within #(
    parameter int COORD_BITS = 24
) (
    input  logic                          clk,
    input  logic signed [COORD_BITS-1:0]  a_x,
    input  logic signed [COORD_BITS-1:0]  a_y,
    input  logic signed [COORD_BITS-1:0]  b_x,
    input  logic signed [COORD_BITS-1:0]  b_y,
    input  logic [popc_pkg::LIM_W-1:0]    lim,
    output logic                          ok
);
    import popc_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int CW = (DW > LIM_W) ? DW : LIM_W;
    localparam int SQ_W = 2 * LIM_W;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [DW-1:0]        ax;
    logic [DW-1:0]        ay;

    logic [CW-1:0]        abs_x_reg;
    logic [CW-1:0]        abs_y_reg;
    logic [LIM_W-1:0]     lim_reg;
    logic                 range_reg;
    logic [SQ_W-1:0]      sqx_reg;
    logic [SQ_W-1:0]      sqy_reg;
    logic [SQ_W-1:0]      limsq_reg;
    logic                 ok_reg;
    logic [SQ_W:0]        sum;

    // stage 1: absolute differences
    assign dx = DW'(a_x) - DW'(b_x);
    assign dy = DW'(a_y) - DW'(b_y);
    assign ax = dx[DW-1] ? $unsigned(-dx) : $unsigned(dx);
    assign ay = dy[DW-1] ? $unsigned(-dy) : $unsigned(dy);

    always_ff @(posedge clk)
    begin
        abs_x_reg <= CW'(ax);
        abs_y_reg <= CW'(ay);
        lim_reg   <= lim;
    end

    // stage 2: range check and squares
    always_ff @(posedge clk)
    begin
        range_reg <= (abs_x_reg < CW'(lim_reg)) && (abs_y_reg < CW'(lim_reg));
        sqx_reg   <= abs_x_reg[LIM_W-1:0] * abs_x_reg[LIM_W-1:0];
        sqy_reg   <= abs_y_reg[LIM_W-1:0] * abs_y_reg[LIM_W-1:0];
        limsq_reg <= lim_reg * lim_reg;
    end

    // stage 3: sum and compare
    assign sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge clk)
    begin
        ok_reg <= range_reg && (sum < {1'b0, limsq_reg});
    end

    assign ok = ok_reg;

endmodule

// ===== design/path_obstacle_proximity_checker.sv =====
// path obstacle proximity checker top level: obstacle memory, scan sequencer, registers
// depends on popc_pkg, popc_within and path_obstacle_proximity_checker_assert.svh
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------
//  input   | in_valid / in_ready    | kind, pos_x, pos_y, last, mission_id
//  output  | out_valid / out_ready  | result_kind, flag
//  config  | cfg_valid / cfg_ready  | cfg_index, cfg_data (cfg_ready always high)
//
// a path point scans the stored obstacles: the memory read port gives one
// obstacle per cycle, then the read register and distance pipeline drain;
// a scan that trips the hit limit stops early. mission updates pass through the
// distance pipeline. no clearing pass after reset: only written entries are read.
// a result waiting on out_ready holds the block in its emit state.
module path_obstacle_proximity_checker #(
    parameter int MAX_OBSTACLES = 1024,
    parameter int COORD_BITS    = 24,
    localparam int CFG_W        = (COORD_BITS > 16) ? COORD_BITS : 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [popc_pkg::KIND_W-1:0]        kind,
    input  logic signed [COORD_BITS-1:0]       pos_x,
    input  logic signed [COORD_BITS-1:0]       pos_y,
    input  logic                               last,
    input  logic [popc_pkg::MISSION_W-1:0]     mission_id,
    // output channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               result_kind,
    output logic                               flag,
    // configuration channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [popc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]                   cfg_data
);
    import popc_pkg::*;

    localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);
    localparam int LAT   = 4;
    localparam int ST_W  = 3;

    localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
    localparam logic [ST_W-1:0] ST_SCAN   = 3'd1;
    localparam logic [ST_W-1:0] ST_MWAIT  = 3'd2;
    localparam logic [ST_W-1:0] ST_FINISH = 3'd3;
    localparam logic [ST_W-1:0] ST_EMIT   = 3'd4;

    // configuration registers
    logic [LIM_W-1:0]             path_limit_reg;
    logic [LIM_W-1:0]             car_limit_reg;
    logic [HLIM_W-1:0]            hit_limit_reg;
    logic [MISSION_W-1:0]         acc_mission_reg;
    logic signed [COORD_BITS-1:0] goal_x_reg;
    logic signed [COORD_BITS-1:0] goal_y_reg;
    logic [LIM_W-1:0]             goal_radius_reg;

    // control state
    logic [ST_W-1:0]              state_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             issue_idx_reg;
    logic [LAT-1:0]               vpipe_reg;
    logic [HIT_W-1:0]             hit_cnt_reg;
    logic [MISSION_W-1:0]         mission_reg;
    logic                         verdict_reg;
    logic                         last_reg;
    logic                         pend_kind_reg;
    logic                         pend_flag_reg;
    logic                         out_valid_reg;
    logic                         result_kind_reg;
    logic                         flag_reg;

    // payload
    logic signed [COORD_BITS-1:0] px_reg;
    logic signed [COORD_BITS-1:0] py_reg;
    logic [2*COORD_BITS-1:0]      mem [MAX_OBSTACLES];
    logic [2*COORD_BITS-1:0]      rd_data_reg;

    logic                         in_beat;
    logic                         wr_en;
    logic                         issue_en;
    logic                         path_ok;
    logic                         car_ok;
    logic                         hit_now;
    logic                         stop_now;
    logic                         out_free;
    logic [HIT_W-1:0]             cnt_inc;
    logic signed [COORD_BITS-1:0] obs_x;
    logic signed [COORD_BITS-1:0] obs_y;
    logic signed [COORD_BITS-1:0] ref_x;
    logic signed [COORD_BITS-1:0] ref_y;
    logic [LIM_W-1:0]             ref_lim;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_beat   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            path_limit_reg  <= PATH_LIMIT_RST;
            car_limit_reg   <= CAR_LIMIT_RST;
            hit_limit_reg   <= HIT_LIMIT_RST;
            acc_mission_reg <= ACC_MISSION_RST;
            goal_x_reg      <= COORD_BITS'(GOAL_X_RST);
            goal_y_reg      <= COORD_BITS'(GOAL_Y_RST);
            goal_radius_reg <= GOAL_RADIUS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PATH_LIMIT:  path_limit_reg  <= cfg_data[LIM_W-1:0];
                REG_CAR_LIMIT:   car_limit_reg   <= cfg_data[LIM_W-1:0];
                REG_HIT_LIMIT:   hit_limit_reg   <= cfg_data[HLIM_W-1:0];
                REG_ACC_MISSION: acc_mission_reg <= cfg_data[MISSION_W-1:0];
                REG_GOAL_X:      goal_x_reg      <= cfg_data[COORD_BITS-1:0];
                REG_GOAL_Y:      goal_y_reg      <= cfg_data[COORD_BITS-1:0];
                REG_GOAL_RADIUS: goal_radius_reg <= cfg_data[LIM_W-1:0];
                default:         ;
            endcase
        end
    end

    // obstacle memory, one write and one registered read per cycle
    assign wr_en = in_beat && (kind == KIND_OBSTACLE) && (count_reg < CNT_W'(MAX_OBSTACLES));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[IDX_W-1:0]] <= {pos_x, pos_y};
        rd_data_reg <= mem[issue_idx_reg[IDX_W-1:0]];
    end

    assign obs_x = rd_data_reg[2*COORD_BITS-1:COORD_BITS];
    assign obs_y = rd_data_reg[COORD_BITS-1:0];

    // shared distance unit: obstacle vs path point, or goal vs vehicle
    assign ref_x   = (state_reg == ST_MWAIT) ? goal_x_reg : obs_x;
    assign ref_y   = (state_reg == ST_MWAIT) ? goal_y_reg : obs_y;
    assign ref_lim = (state_reg == ST_MWAIT) ? goal_radius_reg : path_limit_reg;

    popc_within #(.COORD_BITS(COORD_BITS)) u_path_dist (
        .clk (clk),
        .a_x (px_reg),
        .a_y (py_reg),
        .b_x (ref_x),
        .b_y (ref_y),
        .lim (ref_lim),
        .ok  (path_ok)
    );

    // obstacle vs vehicle origin
    popc_within #(.COORD_BITS(COORD_BITS)) u_car_dist (
        .clk (clk),
        .a_x ('0),
        .a_y ('0),
        .b_x (obs_x),
        .b_y (obs_y),
        .lim (car_limit_reg),
        .ok  (car_ok)
    );

    // scan hit bookkeeping
    assign issue_en = (state_reg == ST_SCAN) && (issue_idx_reg < count_reg);
    assign hit_now  = (state_reg == ST_SCAN) && vpipe_reg[LAT-1] && path_ok && car_ok;
    assign cnt_inc  = (hit_cnt_reg < HIT_MAX) ? hit_cnt_reg + HIT_W'(1) : hit_cnt_reg;
    assign stop_now = hit_now && (cnt_inc > HIT_W'(hit_limit_reg));

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_idx_reg <= '0;
            vpipe_reg     <= '0;
            hit_cnt_reg   <= '0;
            mission_reg   <= '0;
            verdict_reg   <= 1'b0;
            last_reg      <= 1'b0;
            pend_kind_reg <= RES_VERDICT;
            pend_flag_reg <= 1'b0;
        end
        else
        begin
            vpipe_reg <= {vpipe_reg[LAT-2:0], issue_en};
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        unique case (kind)
                            KIND_CLEAR:
                                count_reg <= '0;
                            KIND_OBSTACLE:
                                if (count_reg < CNT_W'(MAX_OBSTACLES))
                                    count_reg <= count_reg + CNT_W'(1);
                            KIND_PATH:
                            begin
                                last_reg      <= last;
                                issue_idx_reg <= '0;
                                if (!verdict_reg && (count_reg != '0))
                                    state_reg <= ST_SCAN;
                                else if (last)
                                    state_reg <= ST_FINISH;
                            end
                            KIND_MISSION:
                            begin
                                mission_reg <= mission_id;
                                vpipe_reg   <= LAT'(1);
                                state_reg   <= ST_MWAIT;
                            end
                            KIND_EMPTY:
                                state_reg <= ST_FINISH;
                            default:
                                ;
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (issue_en)
                        issue_idx_reg <= issue_idx_reg + CNT_W'(1);
                    if (hit_now)
                        hit_cnt_reg <= cnt_inc;
                    if (stop_now)
                    begin
                        verdict_reg <= 1'b1;
                        vpipe_reg   <= '0;
                        state_reg   <= last_reg ? ST_FINISH : ST_IDLE;
                    end
                    else if ((issue_idx_reg == count_reg) && (vpipe_reg == '0))
                        state_reg <= last_reg ? ST_FINISH : ST_IDLE;
                end
                ST_MWAIT:
                begin
                    if (vpipe_reg[LAT-1])
                    begin
                        pend_kind_reg <= RES_GOAL;
                        pend_flag_reg <= path_ok;
                        state_reg     <= ST_EMIT;
                    end
                end
                ST_FINISH:
                begin
                    pend_kind_reg <= RES_VERDICT;
                    pend_flag_reg <= verdict_reg && (mission_reg == acc_mission_reg);
                    if (!verdict_reg)
                        hit_cnt_reg <= '0;
                    verdict_reg <= 1'b0;
                    state_reg   <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // latched point coordinates
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            result_kind_reg <= RES_VERDICT;
            flag_reg        <= 1'b0;
        end
        else if ((state_reg == ST_EMIT) && out_free)
        begin
            out_valid_reg   <= 1'b1;
            result_kind_reg <= pend_kind_reg;
            flag_reg        <= pend_flag_reg;
        end
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = result_kind_reg;
    assign flag        = flag_reg;

    // checks
`include "path_obstacle_proximity_checker_assert.svh"

    `POPC_ASSERT_NOW(a_scan_idx, state_reg == ST_SCAN, issue_idx_reg <= count_reg, "scan index past count")
    `POPC_ASSERT_NOW(a_count_max, 1'b1, count_reg <= CNT_W'(MAX_OBSTACLES), "obstacle count overflow")
    `POPC_ASSERT_NOW(a_mwait_pipe, state_reg == ST_MWAIT, $onehot0(vpipe_reg), "mission pipe corrupt")
    `POPC_ASSERT_NEXT(a_emit_load, (state_reg == ST_EMIT) && out_free, out_valid_reg, "result beat lost")

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for path_obstacle_proximity_checker
// depends on popc_pkg and the design sources; models obstacle store, hit count and goal check
// inputs change on the falling edge, beats and results are sampled on the rising edge
module testbench;

    import popc_pkg::*;

    localparam int XY_W        = 24;
    localparam int CFG_DW      = 24;
    localparam int STORE_DEPTH = 1024;

    // codes the package leaves out
    localparam logic [CFG_IDX_W-1:0] REG_SPARE        = 3'd7;
    localparam logic [KIND_W-1:0]    KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0]    KIND_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [XY_W-1:0]      x;
        logic [XY_W-1:0]      y;
        logic                 last;
        logic [MISSION_W-1:0] mission;
        logic                 typed;
        logic                 want_flag;
    } stim_t;

    typedef struct packed {
        logic rk;
        logic fl;
    } report_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [KIND_W-1:0]       kind;
    logic signed [XY_W-1:0]  pos_x;
    logic signed [XY_W-1:0]  pos_y;
    logic                    last;
    logic [MISSION_W-1:0]    mission_id;
    logic                    out_valid;
    logic                    out_ready;
    logic                    result_kind;
    logic                    flag;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DW-1:0]       cfg_data;

    path_obstacle_proximity_checker dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .last        (last),
        .mission_id  (mission_id),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .flag        (flag),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // clock, period 12
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // run limit
    initial
    begin
        #12000000;
        $display("FAILED: results differ");
        $finish;
    end

    // shadow of the block state and registers
    logic signed [XY_W-1:0] store_x [STORE_DEPTH];
    logic signed [XY_W-1:0] store_y [STORE_DEPTH];
    int unsigned            store_fill;
    int unsigned            hit_tally;
    logic [MISSION_W-1:0]   mission_now;
    bit                     limit_crossed;
    logic [LIM_W-1:0]       r_path_lim;
    logic [LIM_W-1:0]       r_car_lim;
    logic [LIM_W-1:0]       r_goal_rad;
    logic [HLIM_W-1:0]      r_hit_lim;
    logic [MISSION_W-1:0]   r_acc_mission;
    logic signed [XY_W-1:0] r_goal_x;
    logic signed [XY_W-1:0] r_goal_y;

    report_t pending_reports [$];
    int      mismatches = 0;
    bit      idle_on;
    int      hold_request = 0;

    task automatic log_mismatch(input string what);
        mismatches++;
        if (mismatches <= 30)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    function automatic longint unsigned span(input longint a, input longint b);
        longint d;
        d = a - b;
        return (d < 0) ? -d : d;
    endfunction

    // squared distance below lim squared, exact
    function automatic bit closer_than(input longint unsigned ax, input longint unsigned ay,
                                       input int unsigned lim);
        longint unsigned l;
        l = lim;
        if (ax >= l || ay >= l)
            return 1'b0;
        return (ax * ax + ay * ay) < l * l;
    endfunction

    task automatic reset_shadow();
        store_fill    = 0;
        hit_tally     = 0;
        mission_now   = '0;
        limit_crossed = 1'b0;
        r_path_lim    = PATH_LIMIT_RST;
        r_car_lim     = CAR_LIMIT_RST;
        r_hit_lim     = HIT_LIMIT_RST;
        r_acc_mission = ACC_MISSION_RST;
        r_goal_x      = GOAL_X_RST;
        r_goal_y      = GOAL_Y_RST;
        r_goal_rad    = GOAL_RADIUS_RST;
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] v);
        case (idx)
            REG_PATH_LIMIT:  r_path_lim    = v[LIM_W-1:0];
            REG_CAR_LIMIT:   r_car_lim     = v[LIM_W-1:0];
            REG_HIT_LIMIT:   r_hit_lim     = v[HLIM_W-1:0];
            REG_ACC_MISSION: r_acc_mission = v[MISSION_W-1:0];
            REG_GOAL_X:      r_goal_x      = v[XY_W-1:0];
            REG_GOAL_Y:      r_goal_y      = v[XY_W-1:0];
            REG_GOAL_RADIUS: r_goal_rad    = v[LIM_W-1:0];
            default: ;
        endcase
    endtask

    // one path point against the store, stops once the hit count passes the limit
    task automatic sweep_point(input longint px, input longint py);
        for (int i = 0; i < store_fill; i++)
        begin
            if (closer_than(span(px, store_x[i]), span(py, store_y[i]), r_path_lim) &&
                closer_than(span(0, store_x[i]), span(0, store_y[i]), r_car_lim))
            begin
                if (hit_tally < HIT_MAX)
                    hit_tally++;
                if (hit_tally > r_hit_lim)
                begin
                    limit_crossed = 1'b1;
                    return;
                end
            end
        end
    endtask

    task automatic close_path(output report_t r);
        r.rk = RES_VERDICT;
        r.fl = limit_crossed && (mission_now == r_acc_mission);
        if (!limit_crossed)
            hit_tally = 0;
        limit_crossed = 1'b0;
    endtask

    // expected outcome of one accepted input beat
    task automatic evaluate_item(input stim_t s, output bit produced, output report_t r);
        produced = 1'b0;
        r = '0;
        case (s.kind)
            KIND_CLEAR:
                store_fill = 0;
            KIND_OBSTACLE:
                if (store_fill < STORE_DEPTH)
                begin
                    store_x[store_fill] = s.x;
                    store_y[store_fill] = s.y;
                    store_fill++;
                end
            KIND_PATH:
            begin
                if (!limit_crossed)
                    sweep_point($signed(s.x), $signed(s.y));
                if (s.last)
                begin
                    close_path(r);
                    produced = 1'b1;
                end
            end
            KIND_MISSION:
            begin
                mission_now = s.mission;
                r.rk = RES_GOAL;
                r.fl = closer_than(span($signed(s.x), r_goal_x),
                                   span($signed(s.y), r_goal_y), r_goal_rad);
                produced = 1'b1;
            end
            KIND_EMPTY:
            begin
                close_path(r);
                produced = 1'b1;
            end
            default: ;
        endcase
    endtask

    // random helpers
    function automatic int spread(input int unsigned lim);
        return int'($urandom_range(0, 2 * lim)) - int'(lim);
    endfunction

    function automatic logic [XY_W-1:0] wide_coord();
        case ($urandom_range(0, 7))
            0: return {1'b0, {(XY_W-1){1'b1}}};
            1: return {1'b1, {(XY_W-1){1'b0}}};
            default: return $urandom();
        endcase
    endfunction

    function automatic stim_t scatter(input logic [KIND_W-1:0] k);
        stim_t s;
        s.kind      = k;
        s.x         = wide_coord();
        s.y         = wide_coord();
        s.last      = $urandom_range(0, 1);
        s.mission   = $urandom_range(0, 255);
        s.typed     = 1'b0;
        s.want_flag = 1'b0;
        return s;
    endfunction

    function automatic stim_t row(input logic [KIND_W-1:0] k, input int x, input int y,
                                  input bit lst, input int m, input bit typed, input bit want);
        stim_t s;
        s.kind      = k;
        s.x         = x;
        s.y         = y;
        s.last      = lst;
        s.mission   = m;
        s.typed     = typed;
        s.want_flag = want;
        return s;
    endfunction

    function automatic logic [LIM_W-1:0] pick_lim();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // one input beat, with an optional idle burst ahead of it
    task automatic push_item(input stim_t s);
        int      gap;
        bit      produced;
        report_t rep;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= s.kind;
        pos_x      <= s.x;
        pos_y      <= s.y;
        last       <= s.last;
        mission_id <= s.mission;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        evaluate_item(s, produced, rep);
        if (produced)
        begin
            if (s.typed)
            begin
                rep.rk = (s.kind == KIND_MISSION) ? RES_GOAL : RES_VERDICT;
                rep.fl = s.want_flag;
            end
            pending_reports.push_back(rep);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        program_reg(idx, v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // every register plus the unused index, junk in the unused upper bits
    task automatic write_all(input logic [LIM_W-1:0] pl, input logic [LIM_W-1:0] cl,
                             input logic [HLIM_W-1:0] hl, input logic [MISSION_W-1:0] am,
                             input logic [XY_W-1:0] gx, input logic [XY_W-1:0] gy,
                             input logic [LIM_W-1:0] gr);
        logic [CFG_DW-1:0] v;
        v = $urandom();
        write_reg(REG_SPARE, v);
        v = $urandom();
        v[LIM_W-1:0] = pl;
        write_reg(REG_PATH_LIMIT, v);
        v = $urandom();
        v[LIM_W-1:0] = cl;
        write_reg(REG_CAR_LIMIT, v);
        v = $urandom();
        v[HLIM_W-1:0] = hl;
        write_reg(REG_HIT_LIMIT, v);
        v = $urandom();
        v[MISSION_W-1:0] = am;
        write_reg(REG_ACC_MISSION, v);
        write_reg(REG_GOAL_X, gx);
        write_reg(REG_GOAL_Y, gy);
        v = $urandom();
        v[LIM_W-1:0] = gr;
        write_reg(REG_GOAL_RADIUS, v);
    endtask

    // stop offering, wait for all results, then let a full scan drain
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (store_fill + 16) @(posedge clk);
    endtask

    // obstacles mostly near the vehicle, some anywhere
    function automatic stim_t obstacle_near();
        stim_t s;
        s = scatter(KIND_OBSTACLE);
        if ($urandom_range(0, 3) != 0)
        begin
            s.x = spread(r_car_lim);
            s.y = spread(r_car_lim);
        end
        return s;
    endfunction

    // well-formed paths and mission updates with random content, plus noise
    task automatic run_traffic(input int quota);
        int    done;
        int    pick;
        int    pts;
        int    idx;
        stim_t s;
        done = 0;
        if ($urandom_range(0, 4) != 0)
        begin
            push_item(scatter(KIND_CLEAR));
            done++;
        end
        pts = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 12);
        repeat (pts)
        begin
            push_item(obstacle_near());
            done++;
        end
        while (done < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                pts = $urandom_range(1, 4);
                for (int p = 1; p <= pts; p++)
                begin
                    s = scatter(KIND_PATH);
                    if (store_fill > 0 && $urandom_range(0, 3) != 0)
                    begin
                        idx = $urandom_range(0, store_fill - 1);
                        s.x = store_x[idx] + spread(r_path_lim);
                        s.y = store_y[idx] + spread(r_path_lim);
                    end
                    // now and then a path left open, to run into the next one
                    s.last = (p == pts) && ($urandom_range(0, 9) != 0);
                    push_item(s);
                    done++;
                end
            end
            else if (pick < 65)
            begin
                s = scatter(KIND_MISSION);
                if ($urandom_range(0, 9) < 7)
                    s.mission = r_acc_mission;
                if ($urandom_range(0, 9) < 6)
                begin
                    s.x = r_goal_x + spread(r_goal_rad);
                    s.y = r_goal_y + spread(r_goal_rad);
                end
                push_item(s);
                done++;
            end
            else if (pick < 75)
            begin
                push_item(scatter(KIND_EMPTY));
                done++;
            end
            else if (pick < 83)
            begin
                push_item(obstacle_near());
                done++;
            end
            else if (pick < 88)
            begin
                push_item(scatter(KIND_CLEAR));
                done++;
            end
            else if (pick < 93)
                push_item(scatter($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)));
            else
            begin
                push_item(scatter($urandom_range(KIND_CLEAR, KIND_EMPTY)));
                done++;
            end
        end
    endtask

    task automatic reprogram_random();
        logic [HLIM_W-1:0] hl;
        logic [MISSION_W-1:0] am;
        case ($urandom_range(0, 3))
            0: hl = '0;
            1: hl = '1;
            default: hl = $urandom_range(0, 3);
        endcase
        am = ($urandom_range(0, 3) == 0) ? '1 : $urandom_range(0, 255);
        write_all(pick_lim(), pick_lim(), hl, am, wide_coord(), wide_coord(), pick_lim());
    endtask

    // hit counter driven to its ceiling: one path passes the limit, then one hit per path
    task automatic run_saturation();
        logic [MISSION_W-1:0] m;
        stim_t s;
        m = $urandom_range(0, 255);
        write_all('1, '1, '1, m, wide_coord(), wide_coord(), pick_lim());
        push_item(scatter(KIND_CLEAR));
        s = scatter(KIND_MISSION);
        s.mission = m;
        push_item(s);
        repeat (40)
        begin
            s = scatter(KIND_OBSTACLE);
            s.x = spread(1000);
            s.y = spread(1000);
            push_item(s);
        end
        for (int p = 1; p <= 7; p++)
        begin
            s = scatter(KIND_PATH);
            s.x = spread(1000);
            s.y = spread(1000);
            s.last = (p == 7);
            push_item(s);
        end
        repeat (270)
        begin
            s = scatter(KIND_PATH);
            s.x = spread(1000);
            s.y = spread(1000);
            s.last = 1'b1;
            push_item(s);
        end
    endtask

    // store filled past capacity: the last kept entry counts, the dropped ones do not
    task automatic run_overflow();
        logic [MISSION_W-1:0] m;
        stim_t s;
        m = $urandom_range(0, 255);
        write_all(16'd100, 16'd1000, '0, m, wide_coord(), wide_coord(), pick_lim());
        push_item(scatter(KIND_CLEAR));
        s = scatter(KIND_MISSION);
        s.mission = m;
        push_item(s);
        repeat (STORE_DEPTH - 1)
        begin
            s = scatter(KIND_OBSTACLE);
            s.x = ($urandom_range(0, 1) ? 1 : -1) * (2000 + int'($urandom_range(0, 100000)));
            s.y = spread(2000);
            push_item(s);
        end
        push_item(row(KIND_OBSTACLE, 500, 500, 1'b0, 0, 1'b0, 1'b0));
        repeat (6)
        begin
            s = scatter(KIND_OBSTACLE);
            s.x = spread(30);
            s.y = spread(30);
            push_item(s);
        end
        push_item(row(KIND_PATH, spread(20), spread(20), 1'b1, 0, 1'b0, 1'b0));
        push_item(row(KIND_PATH, 500 + spread(20), 500 + spread(20), 1'b1, 0, 1'b0, 1'b0));
        push_item(scatter(KIND_EMPTY));
    endtask

    // result side: random stall bursts and the long hold-off on request
    initial
    begin : result_sink
        int stall;
        stall = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_request) @(negedge clk);
                hold_request = 0;
                out_ready <= 1'b1;
            end
            else if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 9) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin : result_check
        report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
                log_mismatch($sformatf("result kind %0b flag %0b with nothing expected",
                                       result_kind, flag));
            else
            begin
                want = pending_reports.pop_front();
                if (result_kind !== want.rk)
                    log_mismatch($sformatf("result_kind %0b, expected %0b",
                                           result_kind, want.rk));
                if (flag !== want.fl)
                    log_mismatch($sformatf("flag %0b, expected %0b (result_kind %0b)",
                                           flag, want.fl, want.rk));
            end
        end
    end

    initial
    begin : stimulus
        stim_t rows [$];
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        kind       = KIND_CLEAR;
        pos_x      = '0;
        pos_y      = '0;
        last       = 1'b0;
        mission_id = '0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_PATH_LIMIT;
        cfg_data   = '0;
        idle_on    = 1'b1;
        reset_shadow();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows under the reset settings
        rows.push_back(row(KIND_EMPTY, 0, 0, 1'b0, 0, 1'b1, 1'b0));
        rows.push_back(row(KIND_PATH, 0, 0, 1'b1, 0, 1'b1, 1'b0));
        rows.push_back(row(KIND_MISSION, 157184, -142080, 1'b0, 5, 1'b1, 1'b1));
        rows.push_back(row(KIND_MISSION, 157951, -142080, 1'b1, 5, 1'b1, 1'b1));
        rows.push_back(row(KIND_MISSION, 157952, -142080, 1'b0, 5, 1'b1, 1'b0));
        rows.push_back(row(KIND_MISSION, 8388607, -8388608, 1'b1, 5, 1'b1, 1'b0));
        rows.push_back(row(KIND_OBSTACLE, 0, 0, 1'b1, 255, 1'b0, 1'b0));
        rows.push_back(row(KIND_OBSTACLE, 100, 0, 1'b0, 0, 1'b0, 1'b0));
        rows.push_back(row(KIND_OBSTACLE, 2559, 0, 1'b0, 0, 1'b0, 1'b0));
        rows.push_back(row(KIND_OBSTACLE, 2560, 0, 1'b0, 0, 1'b0, 1'b0));
        rows.push_back(row(KIND_PATH, 50, 0, 1'b0, 255, 1'b0, 1'b0));
        rows.push_back(row(KIND_PATH, -8388608, 8388607, 1'b1, 0, 1'b1, 1'b1));
        rows.push_back(row(KIND_PATH, 2560, 0, 1'b1, 0, 1'b0, 1'b0));
        rows.push_back(row(KIND_SPARE_FIRST, -8388608, -8388608, 1'b1, 255, 1'b0, 1'b0));
        rows.push_back(row(3'd6, 8388607, 8388607, 1'b0, 0, 1'b0, 1'b0));
        rows.push_back(row(KIND_SPARE_LAST, -1, 0, 1'b1, 170, 1'b0, 1'b0));
        rows.push_back(row(KIND_MISSION, 0, 0, 1'b0, 255, 1'b1, 1'b0));
        rows.push_back(row(KIND_PATH, 0, 0, 1'b1, 0, 1'b0, 1'b0));
        rows.push_back(row(KIND_EMPTY, -1, -1, 1'b1, 255, 1'b0, 1'b0));
        rows.push_back(row(KIND_OBSTACLE, 8388607, -8388608, 1'b0, 0, 1'b0, 1'b0));
        rows.push_back(row(KIND_PATH, 8388607, -8388608, 1'b1, 0, 1'b0, 1'b0));
        rows.push_back(row(KIND_CLEAR, 8388607, 8388607, 1'b1, 255, 1'b0, 1'b0));
        rows.push_back(row(KIND_PATH, 0, 0, 1'b1, 0, 1'b1, 1'b0));
        rows.push_back(row(KIND_MISSION, -8388608, 8388607, 1'b0, 5, 1'b0, 1'b0));
        foreach (rows[i])
            push_item(rows[i]);
        settle();

        // phases: reset values, low extremes, high extremes with hold-off, saturation, random, overflow, then random
        write_all(PATH_LIMIT_RST, CAR_LIMIT_RST, HIT_LIMIT_RST, ACC_MISSION_RST,
                  GOAL_X_RST, GOAL_Y_RST, GOAL_RADIUS_RST);
        run_traffic(35);
        settle();
        write_all('0, '0, '0, '0, {1'b1, {(XY_W-1){1'b0}}}, {1'b1, {(XY_W-1){1'b0}}}, '0);
        run_traffic(30);
        settle();
        write_all('1, '1, '1, '1, {1'b0, {(XY_W-1){1'b1}}}, {1'b0, {(XY_W-1){1'b1}}}, '1);
        hold_request = 300;
        run_traffic(35);
        settle();
        run_saturation();
        settle();
        reprogram_random();
        run_traffic(35);
        settle();
        run_overflow();
        settle();
        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph >= 3)
                idle_on = 1'b0;
            reprogram_random();
            run_traffic(35);
            settle();
        end

        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
